>>> rtl/tmq_pkg.sv
// Package for the tagged mailbox queue: word types, command and status codes,
// and default sizes. Used by tagged_mailbox_queue; it depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tmq_pkg;

  localparam int DEFAULT_RING_DEPTH   = 16;
  localparam int DEFAULT_PAYLOAD_BITS = 32;
  localparam int ID_W                 = 2;
  localparam int PORT_WORD_W          = 32;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_RECV = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_SENT     = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_RECEIVED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                   command;
    logic [ID_W-1:0]        requester;
    logic [ID_W-1:0]        destination;
    logic [PORT_WORD_W-1:0] payload;
  } in_word_t;

  typedef struct packed {
    status_t                status;
    logic [ID_W-1:0]        from_sender;
    logic [PORT_WORD_W-1:0] message_word;
  } out_word_t;

endpackage

`default_nettype wire

>>> rtl/tmq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the mailbox slots; depends on no package.
`timescale 1ns / 1ps
`default_nettype none

module tmq_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tagged_mailbox_queue.sv
// Tagged mailbox queue top level: sequencer, ring pointers and result register.
// Depends on tmq_pkg and instantiates tmq_ram for the message slots.
//
// A send is handled directly from idle: the word is written at the tail, or
// refused when the ring is full, and the result strobe follows in the next
// cycle. A receive walks the ring from the head through the single read port
// of the slot RAM, reading and then comparing each slot examined; when the
// match is not at the head, every later message is moved down one slot, again
// by a read and then a write per slot. The slots scanned plus the messages
// moved never exceed the number of messages held. busy stays high until the
// ring is consistent again. The result appears on out_word for exactly one
// cycle with out_valid high; the receiver cannot hold it off, so it must
// capture the word in that cycle.
`timescale 1ns / 1ps
`default_nettype none

module tagged_mailbox_queue #(
  parameter int RING_DEPTH   = tmq_pkg::DEFAULT_RING_DEPTH,
  parameter int PAYLOAD_BITS = tmq_pkg::DEFAULT_PAYLOAD_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire tmq_pkg::in_word_t in_word,
  output      logic              out_valid,
  output      tmq_pkg::out_word_t out_word
);

  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int WORD_W = (PAYLOAD_BITS < tmq_pkg::PORT_WORD_W) ? PAYLOAD_BITS
                                                                : tmq_pkg::PORT_WORD_W;
  localparam int ID_W   = tmq_pkg::ID_W;
  localparam int ENT_W  = 2 * ID_W + WORD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  state_t             state_r;
  logic [IDX_W-1:0]   head_r;
  logic [IDX_W-1:0]   tail_r;
  logic               full_r;
  logic [IDX_W-1:0]   slot_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   left_r;
  logic [ID_W-1:0]    who_r;
  logic               out_valid_r;
  tmq_pkg::out_word_t out_word_r;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENT_W-1:0]   ram_rdata;

  logic               accept;
  logic [CNT_W-1:0]   occupancy;
  logic [ID_W-1:0]    rd_sender;
  logic [ID_W-1:0]    rd_receiver;
  logic [WORD_W-1:0]  rd_word;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
    next_slot = (s == IDX_W'(RING_DEPTH - 1)) ? '0 : s + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] s);
    prev_slot = (s == '0) ? IDX_W'(RING_DEPTH - 1) : s - IDX_W'(1);
  endfunction

  assign accept      = start && !busy;
  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_word    = out_word_r;
  assign rd_sender   = ram_rdata[ENT_W-1 -: ID_W];
  assign rd_receiver = ram_rdata[WORD_W +: ID_W];
  assign rd_word     = ram_rdata[WORD_W-1:0];

  // A full ring holds every slot even though head and tail coincide.
  always_comb begin
    if (full_r) begin
      occupancy = CNT_W'(RING_DEPTH);
    end else if (tail_r >= head_r) begin
      occupancy = CNT_W'(tail_r) - CNT_W'(head_r);
    end else begin
      occupancy = CNT_W'(tail_r) + CNT_W'(RING_DEPTH) - CNT_W'(head_r);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    ram_wdata = {in_word.requester, in_word.destination, in_word.payload[WORD_W-1:0]};
    ram_re    = 1'b0;
    ram_raddr = slot_r;
    case (state_r)
      S_IDLE: begin
        ram_we = accept && (in_word.command == tmq_pkg::CMD_SEND) && !full_r;
      end
      S_SCAN_RD: begin
        ram_re = 1'b1;
      end
      S_SHIFT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = next_slot(slot_r);
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  tmq_ram #(
    .WIDTH(ENT_W),
    .DEPTH(RING_DEPTH)
  ) u_slots (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_word_r  <= '0;
      slot_r      <= '0;
      idx_r       <= '0;
      count_r     <= '0;
      left_r      <= '0;
      who_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_word.command == tmq_pkg::CMD_SEND) begin
              out_valid_r <= 1'b1;
              out_word_r  <= '{status: full_r ? tmq_pkg::ST_REFUSED : tmq_pkg::ST_SENT,
                               default: '0};
              if (!full_r) begin
                tail_r <= next_slot(tail_r);
                if (next_slot(tail_r) == head_r) begin
                  full_r <= 1'b1;
                end
              end
            end else if (occupancy == '0) begin
              out_valid_r <= 1'b1;
              out_word_r  <= '{status: tmq_pkg::ST_EMPTY, default: '0};
            end else begin
              who_r   <= in_word.requester;
              slot_r  <= head_r;
              idx_r   <= '0;
              count_r <= occupancy;
              state_r <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state_r <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (rd_receiver == who_r) begin
            out_valid_r <= 1'b1;
            out_word_r  <= '{status: tmq_pkg::ST_RECEIVED,
                             from_sender: rd_sender,
                             message_word: tmq_pkg::PORT_WORD_W'(rd_word)};
            full_r      <= 1'b0;
            if (idx_r == '0) begin
              head_r  <= next_slot(head_r);
              state_r <= S_IDLE;
            end else if ((idx_r + CNT_W'(1)) == count_r) begin
              // The match was the newest message: nothing to move down.
              tail_r  <= prev_slot(tail_r);
              state_r <= S_IDLE;
            end else begin
              left_r  <= count_r - CNT_W'(1) - idx_r;
              state_r <= S_SHIFT_RD;
            end
          end else if ((idx_r + CNT_W'(1)) == count_r) begin
            out_valid_r <= 1'b1;
            out_word_r  <= '{status: tmq_pkg::ST_EMPTY, default: '0};
            state_r     <= S_IDLE;
          end else begin
            slot_r  <= next_slot(slot_r);
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: begin
          state_r <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          slot_r <= next_slot(slot_r);
          left_r <= left_r - CNT_W'(1);
          if (left_r == CNT_W'(1)) begin
            tail_r  <= prev_slot(tail_r);
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SHIFT_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // A full ring always has its head and tail on the same slot.
  a_full_pointers: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (head_r == tail_r))
    else $error("full ring with head and tail apart");

  // A send never leaves the idle state and reports in the next cycle.
  a_send_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.command == tmq_pkg::CMD_SEND) |=>
      (out_valid && !busy &&
       (out_word.status == tmq_pkg::ST_SENT || out_word.status == tmq_pkg::ST_REFUSED)))
    else $error("send did not complete in one cycle");

  // Only a received word carries a sender and a message.
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status != tmq_pkg::ST_RECEIVED) |->
      (out_word.from_sender == '0 && out_word.message_word == '0))
    else $error("non-receive result carries data");

  // The compaction pass only runs after a match away from the head.
  a_shift_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_RD || state_r == S_SHIFT_WR) |-> (left_r != '0 && !full_r))
    else $error("compaction running with nothing left to move");

  // A result is only produced while the sequencer finishes an item.
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD || state_r == S_SHIFT_RD) |=> !out_valid)
    else $error("result strobe outside a completion point");

endmodule

`default_nettype wire
